[rtl/chained_string_hash_table_core_assert.svh]
// Assertion macros for the hash table core
`ifndef CHAINED_STRING_HASH_TABLE_CORE_ASSERT_SVH
`define CHAINED_STRING_HASH_TABLE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define CSHT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define CSHT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define CSHT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CSHT_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/csht_pkg.sv]
// Package: constants, codes and types of the hash table core
`default_nettype none
package csht_pkg;
  localparam int Buckets = 1024;
  localparam int Ways = 4;
  localparam int KeyBytes = 16;
  localparam int BktW = $clog2(Buckets);
  localparam int WayW = (Ways > 1) ? $clog2(Ways) : 1;
  localparam int FillW = $clog2(Ways + 1);
  localparam int KeyIdxW = (KeyBytes > 1) ? $clog2(KeyBytes) : 1;
  localparam int LenW = $clog2(KeyBytes + 1);
  localparam int SlotW = BktW + WayW;
  localparam int ByteAddrW = SlotW + KeyIdxW;
  localparam int OutBktW = 10;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_FULL     = 3'd1,
    ST_FOUND    = 3'd2,
    ST_MISSING  = 3'd3,
    ST_TOO_LONG = 3'd4
  } status_t;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_SEARCH = 1'b1;

  typedef struct packed {
    logic [30:0] hash_value;
    logic        search;
    logic        too_long;
    logic [LenW-1:0] len;
  } key_info_t;
endpackage
`default_nettype wire

[rtl/csht_if.sv]
// Valid/ready channel interfaces
`default_nettype none
interface csht_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] key_byte;
  logic       last;
  modport source (output valid, func, key_byte, last, input ready);
  modport sink (input valid, func, key_byte, last, output ready);
endinterface

interface csht_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [9:0]  bucket;
  logic [30:0] hash_value;
  modport source (output valid, status, bucket, hash_value, input ready);
  modport sink (input valid, status, bucket, hash_value, output ready);
endinterface
`default_nettype wire

[rtl/csht_ram.sv]
// Generic single-port-write, registered-read RAM
`default_nettype none
module csht_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output      logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[rtl/csht_hash.sv]
// Byte intake: running hash, key buffer and length
`default_nettype none
module csht_hash (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          take,
  input  wire logic                          func,
  input  wire logic [7:0]                    key_byte,
  input  wire logic                          last,
  input  wire logic [csht_pkg::KeyIdxW-1:0]  kraddr,
  output      logic [7:0]                    krdata,
  output      logic                          done,
  output      csht_pkg::key_info_t           info
);
  logic [31:0] hash_r, hash_nxt;
  logic [csht_pkg::LenW-1:0] len_r, len_nxt;
  logic tl_r, tl_nxt;
  logic room;

  assign hash_nxt = hash_r * 32'd131 + {24'd0, key_byte};
  assign room = len_r < csht_pkg::LenW'(csht_pkg::KeyBytes);

  csht_ram #(.Width(8), .Depth(csht_pkg::KeyBytes)) u_kbuf (
    .clk(clk), .we(take && room), .waddr(len_r[csht_pkg::KeyIdxW-1:0]),
    .wdata(key_byte), .raddr(kraddr), .rdata(krdata));

  always_comb begin
    len_nxt = len_r;
    tl_nxt = tl_r;
    if (room) len_nxt = len_r + 1'b1;
    else tl_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r <= '0;
      len_r <= '0;
      tl_r <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= take && last;
      if (take) begin
        if (last) begin
          hash_r <= '0;
          len_r <= '0;
          tl_r <= 1'b0;
        end else begin
          hash_r <= hash_nxt;
          len_r <= len_nxt;
          tl_r <= tl_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && last) begin
      info.hash_value <= hash_nxt[30:0];
      info.search <= (func != csht_pkg::FUNC_INSERT);
      info.too_long <= tl_nxt;
      info.len <= len_nxt;
    end
  end
endmodule
`default_nettype wire

[rtl/csht_table.sv]
// Bucket table engine: fill counts, stored keys, insert and search
`default_nettype none
module csht_table (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire csht_pkg::key_info_t           info,
  output      logic [csht_pkg::KeyIdxW-1:0]  kraddr,
  input  wire logic [7:0]                    krdata,
  output      logic                          busy,
  output      logic                          res_valid,
  input  wire logic                          res_ready,
  output      logic [2:0]                    res_status,
  output      logic [9:0]                    res_bucket,
  output      logic [30:0]                   res_hash
);
  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_CLEAR = 8'b0000_0010,
    S_MOD   = 8'b0000_0100,
    S_FILL  = 8'b0000_1000,
    S_COPY  = 8'b0001_0000,
    S_SLOT  = 8'b0010_0000,
    S_CMP   = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  localparam int BktW = csht_pkg::BktW;
  localparam int FillW = csht_pkg::FillW;
  localparam int WayW = csht_pkg::WayW;
  localparam int KW = csht_pkg::KeyIdxW;
  localparam int LenW = csht_pkg::LenW;

  state_t st_r;
  logic [BktW:0] clr_r;
  logic [30:0] rem_r;
  logic [BktW-1:0] bkt;
  logic [FillW-1:0] fill_r;
  logic [FillW-1:0] fill_rd;
  logic [WayW:0] way_r;
  logic [LenW:0] bi_r;
  logic [2:0] status_r;
  logic match_r;
  logic [LenW-1:0] slen_rd;
  logic [7:0] sbyte_rd;
  logic f_we, l_we, b_we;
  logic [BktW-1:0] f_addr;
  logic [FillW-1:0] f_wd;
  logic [csht_pkg::SlotW-1:0] slot;
  logic [csht_pkg::ByteAddrW-1:0] b_waddr, b_raddr;
  logic [KW-1:0] bi_idx, bi_prev;
  logic cmp_phase;
  logic res_load;
  logic res_v_r;
  logic [2:0] res_st_r;
  logic [9:0] res_bkt_r;
  logic [30:0] res_hash_r;

  // remainder by repeated conditional subtract, one bit per cycle would be long;
  // Buckets is a power of two here so the mask path is used when possible
  localparam bit Pow2 = (csht_pkg::Buckets & (csht_pkg::Buckets - 1)) == 0;
  assign bkt = BktW'(rem_r);

  assign f_we = (st_r == S_CLEAR) || (st_r == S_COPY && bi_r == '0);
  assign f_addr = (st_r == S_CLEAR) ? clr_r[BktW-1:0] : bkt;
  assign f_wd = (st_r == S_CLEAR) ? '0 : fill_r + 1'b1;
  csht_ram #(.Width(FillW), .Depth(csht_pkg::Buckets)) u_fill (
    .clk(clk), .we(f_we), .waddr(f_addr), .wdata(f_wd), .raddr(bkt), .rdata(fill_rd));

  assign slot = (st_r == S_COPY) ? {bkt, fill_r[WayW-1:0]} : {bkt, way_r[WayW-1:0]};
  assign l_we = (st_r == S_COPY) && bi_r == '0;
  csht_ram #(.Width(LenW), .Depth(csht_pkg::Buckets * csht_pkg::Ways)) u_len (
    .clk(clk), .we(l_we), .waddr(slot), .wdata(info.len), .raddr(slot), .rdata(slen_rd));

  // copy: key buffer data arrives the cycle after its read, bi_r counts reads issued
  assign bi_idx = KW'(bi_r);
  assign bi_prev = KW'(bi_r - 1'b1);
  assign kraddr = bi_idx;
  assign b_we = (st_r == S_COPY) && bi_r != '0;
  assign b_waddr = {slot, bi_prev};
  assign b_raddr = {slot, bi_idx};
  csht_ram #(.Width(8), .Depth(csht_pkg::Buckets * csht_pkg::Ways * csht_pkg::KeyBytes)) u_keys (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(krdata), .raddr(b_raddr), .rdata(sbyte_rd));

  assign cmp_phase = bi_r != '0;
  assign busy = st_r != S_IDLE;
  assign res_load = (st_r == S_OUT) && (!res_v_r || res_ready);
  assign res_valid = res_v_r;
  assign res_status = res_st_r;
  assign res_bucket = res_bkt_r;
  assign res_hash = res_hash_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLEAR;
      clr_r <= '0;
    end else begin
      unique case (st_r)
        S_IDLE: if (start) begin
          rem_r <= info.hash_value;
          st_r <= S_MOD;
        end
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == (BktW+1)'(csht_pkg::Buckets - 1)) st_r <= S_IDLE;
        end
        S_MOD: begin
          if (Pow2 || rem_r < 31'(csht_pkg::Buckets)) begin
            if (Pow2) rem_r <= 31'(bkt);
            st_r <= S_FILL;
          end else if (rem_r[30:BktW] != '0 && rem_r >= 31'(csht_pkg::Buckets) << 8) begin
            rem_r <= rem_r - (31'(csht_pkg::Buckets) << 8);
          end else begin
            rem_r <= rem_r - 31'(csht_pkg::Buckets);
          end
        end
        S_FILL: begin
          fill_r <= fill_rd;
          way_r <= '0;
          bi_r <= '0;
          match_r <= 1'b0;
          if (info.too_long) begin
            status_r <= csht_pkg::ST_TOO_LONG;
            st_r <= S_OUT;
          end else if (!info.search) begin
            if (fill_rd >= FillW'(csht_pkg::Ways)) begin
              status_r <= csht_pkg::ST_FULL;
              st_r <= S_OUT;
            end else st_r <= S_COPY;
          end else if (fill_rd == '0) begin
            status_r <= csht_pkg::ST_MISSING;
            st_r <= S_OUT;
          end else st_r <= S_SLOT;
        end
        S_COPY: begin
          bi_r <= bi_r + 1'b1;
          if (bi_r == (LenW+1)'(info.len)) begin
            status_r <= csht_pkg::ST_INSERTED;
            st_r <= S_OUT;
          end
        end
        S_SLOT: begin
          bi_r <= '0;
          match_r <= 1'b1;
          st_r <= S_CMP;
        end
        S_CMP: begin
          // bi_r==0: length of slot is ready; later: byte bi_r-1 is ready
          bi_r <= bi_r + 1'b1;
          if (!cmp_phase) begin
            if (slen_rd != info.len) match_r <= 1'b0;
          end else if (sbyte_rd != krdata) match_r <= 1'b0;
          if (bi_r == (LenW+1)'(info.len)) begin
            if (match_r && (!cmp_phase ? slen_rd == info.len : sbyte_rd == krdata)) begin
              status_r <= csht_pkg::ST_FOUND;
              st_r <= S_OUT;
            end else if (way_r + 1'b1 == (WayW+1)'(fill_r)) begin
              status_r <= csht_pkg::ST_MISSING;
              st_r <= S_OUT;
            end else begin
              way_r <= way_r + 1'b1;
              st_r <= S_SLOT;
            end
          end
        end
        S_OUT: if (res_load) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_v_r <= 1'b0;
    end else if (res_load) begin
      res_v_r <= 1'b1;
      res_st_r <= status_r;
      res_bkt_r <= 10'(bkt);
      res_hash_r <= info.hash_value;
    end else if (res_ready) begin
      res_v_r <= 1'b0;
    end
  end
endmodule
`default_nettype wire

[rtl/chained_string_hash_table_core.sv]
// Top level of the chained string hash table core
//  channel | dir | words
//  in_     | in  | func, key_byte, last
//  out_    | out | status, bucket, hash_value
// One key byte is taken per cycle while input is not refused. After the last byte, input
// is refused until the engine has finished the key: the insert, a full bucket, a too
// long key, an empty bucket on a search, or the search of each stored way compared.
// A finished word waits in an output register, so the next key's bytes flow while
// it is unread; the engine stalls only when a second word is ready before it.
// After reset a clearing pass over all 1024 buckets zeroes the fill counts.
`default_nettype none
`include "chained_string_hash_table_core_assert.svh"
module chained_string_hash_table_core (
  input wire logic   clk,
  input wire logic   rst_n,
  csht_in_if.sink    in_ch,
  csht_out_if.source out_ch
);
  logic take, done, busy;
  logic [csht_pkg::KeyIdxW-1:0] kraddr;
  logic [7:0] krdata;
  csht_pkg::key_info_t info;
  logic hold_r;

  assign in_ch.ready = !busy && !done && !hold_r;
  assign take = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) hold_r <= 1'b0;
    else hold_r <= take && in_ch.last;
  end

  csht_hash u_hash (
    .clk(clk), .rst_n(rst_n), .take(take), .func(in_ch.func), .key_byte(in_ch.key_byte),
    .last(in_ch.last), .kraddr(kraddr), .krdata(krdata), .done(done), .info(info));

  csht_table u_table (
    .clk(clk), .rst_n(rst_n), .start(done), .info(info), .kraddr(kraddr),
    .krdata(krdata), .busy(busy), .res_valid(out_ch.valid), .res_ready(out_ch.ready),
    .res_status(out_ch.status), .res_bucket(out_ch.bucket), .res_hash(out_ch.hash_value));

  `CSHT_ASSERT_IMP(a_no_take_busy, clk, rst_n, busy, !take)
  `CSHT_ASSERT_NXT(a_last_blocks, clk, rst_n, take && in_ch.last, !in_ch.ready)
  `CSHT_ASSERT_IMP(a_out_known, clk, rst_n, out_ch.valid, out_ch.status <= 3'd4)
endmodule
`default_nettype wire

[verif/tb_chained_string_hash_table_core.sv]
// Testbench for the chained string hash table core: random key traffic, scoreboard
`default_nettype none
module tb_chained_string_hash_table_core;

  typedef struct {
    csht_pkg::status_t st;
    logic [9:0]  bkt;
    logic [30:0] hv;
  } lookup_t;

  typedef struct {
    logic [7:0] b [40];
    int         n;
  } key_t;

  class hash_table_scoreboard;
    logic [31:0] run_hash;
    logic [7:0]  cur_key [csht_pkg::KeyBytes];
    int          cur_len;
    bit          cur_long;
    int          fill [csht_pkg::Buckets];
    logic [7:0]  slot_bytes [csht_pkg::Buckets][csht_pkg::Ways][csht_pkg::KeyBytes];
    int          slot_len [csht_pkg::Buckets][csht_pkg::Ways];
    lookup_t     pending [$];
    int          errors;
    int          results;
    int          st_seen [5];

    function new();
      run_hash = '0;
      cur_len  = 0;
      cur_long = 0;
      errors   = 0;
      results  = 0;
      foreach (fill[i]) fill[i] = 0;
      foreach (st_seen[i]) st_seen[i] = 0;
    endfunction

    function bit slot_match(int bk, int w);
      if (slot_len[bk][w] != cur_len) return 0;
      for (int i = 0; i < cur_len; i++)
        if (slot_bytes[bk][w][i] != cur_key[i]) return 0;
      return 1;
    endfunction

    function void note_word(logic func, logic [7:0] kb, logic last);
      lookup_t e;
      int bk;
      run_hash = run_hash * 32'd131 + {24'd0, kb};
      if (cur_len < csht_pkg::KeyBytes) begin
        cur_key[cur_len] = kb;
        cur_len++;
      end else begin
        cur_long = 1;
      end
      if (!last) return;
      e.hv  = run_hash[30:0];
      bk    = int'(e.hv % csht_pkg::Buckets);
      e.bkt = bk[9:0];
      if (cur_long) begin
        e.st = csht_pkg::ST_TOO_LONG;
      end else if (func == csht_pkg::FUNC_INSERT) begin
        if (fill[bk] >= csht_pkg::Ways) begin
          e.st = csht_pkg::ST_FULL;
        end else begin
          for (int i = 0; i < cur_len; i++) slot_bytes[bk][fill[bk]][i] = cur_key[i];
          slot_len[bk][fill[bk]] = cur_len;
          fill[bk]++;
          e.st = csht_pkg::ST_INSERTED;
        end
      end else begin
        e.st = csht_pkg::ST_MISSING;
        for (int w = 0; w < fill[bk]; w++)
          if (slot_match(bk, w)) e.st = csht_pkg::ST_FOUND;
      end
      pending = {pending, e};
      run_hash = '0;
      cur_len  = 0;
      cur_long = 0;
    endfunction

    function void check_result(logic [2:0] st, logic [9:0] bkt, logic [30:0] hv);
      lookup_t e;
      results++;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: st=%0d bkt=%0d hv=%h", st, bkt, hv);
        return;
      end
      e = pending.pop_front();
      st_seen[e.st]++;
      if (st !== e.st || bkt !== e.bkt || hv !== e.hv) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp st=%0d bkt=%0d hv=%h, got st=%0d bkt=%0d hv=%h",
                   e.st, e.bkt, e.hv, st, bkt, hv);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  csht_in_if  in_ch ();
  csht_out_if out_ch ();

  chained_string_hash_table_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  hash_table_scoreboard sb;
  int   idle_pct;
  int   stall_pct;
  int   hold_seq;
  int   hold_seen;
  int   hold_left;
  int   quiet_cycles;
  int   words_sent;
  key_t stored_keys [$];

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) sb.note_word(in_ch.func, in_ch.key_byte, in_ch.last);
    if (out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.status, out_ch.bucket, out_ch.hash_value);
  end

  // receiver: random stalls plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = 400;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
    else quiet_cycles = quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("timeout: no handshake for %0d cycles", quiet_cycles);
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_word(logic func, logic [7:0] kb, logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.func     <= func;
    in_ch.key_byte <= kb;
    in_ch.last     <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_key(logic func, key_t k);
    for (int i = 0; i < k.n; i++) send_word(func, k.b[i], i == k.n - 1);
  endtask

  function automatic key_t rand_key(int lo, int hi);
    key_t k;
    k.n = $urandom_range(hi, lo);
    foreach (k.b[i]) k.b[i] = 8'($urandom_range(255));
    return k;
  endfunction

  task automatic insert_key(key_t k);
    send_key(csht_pkg::FUNC_INSERT, k);
    if (k.n <= csht_pkg::KeyBytes) stored_keys = {stored_keys, k};
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  task automatic random_traffic(int words);
    int stop;
    int pick;
    key_t k;
    stop = words_sent + words;
    while (words_sent < stop) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        insert_key(rand_key(1, ($urandom_range(9) == 0) ? csht_pkg::KeyBytes : 6));
      end else if (pick < 75 && stored_keys.size() > 0) begin
        send_key(csht_pkg::FUNC_SEARCH, stored_keys[$urandom_range(stored_keys.size() - 1)]);
      end else if (pick < 85) begin
        send_key(csht_pkg::FUNC_SEARCH, rand_key(1, csht_pkg::KeyBytes));
      end else if (pick < 92) begin
        send_key(1'($urandom_range(1)), rand_key(csht_pkg::KeyBytes + 1, 40));
      end else if (stored_keys.size() > 0) begin
        k = stored_keys[$urandom_range(stored_keys.size() - 1)];
        send_key(csht_pkg::FUNC_INSERT, k);
      end
    end
  endtask

  initial begin
    key_t k;
    key_t p;
    sb = new();
    idle_pct = 0;
    stall_pct = 0;
    hold_seq = 0;
    hold_seen = 0;
    hold_left = 0;
    quiet_cycles = 0;
    words_sent = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.func = 1'b0;
    in_ch.key_byte = 8'd0;
    in_ch.last = 1'b0;
    out_ch.ready = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, both operations, full bucket, too long, prefix miss
    k.n = 1; k.b[0] = 8'h00;
    insert_key(k);
    send_key(csht_pkg::FUNC_SEARCH, k);
    k.b[0] = 8'hFF;
    send_key(csht_pkg::FUNC_SEARCH, k);
    insert_key(k);
    send_key(csht_pkg::FUNC_SEARCH, k);
    k.n = csht_pkg::KeyBytes;
    foreach (k.b[i]) k.b[i] = (i % 2) ? 8'hFF : 8'h00;
    insert_key(k);
    send_key(csht_pkg::FUNC_SEARCH, k);
    p = k; p.n = csht_pkg::KeyBytes - 1;
    send_key(csht_pkg::FUNC_SEARCH, p);
    p = k; p.n = csht_pkg::KeyBytes + 1;
    send_key(csht_pkg::FUNC_INSERT, p);
    send_key(csht_pkg::FUNC_SEARCH, p);
    k = rand_key(3, 3);
    for (int i = 0; i <= csht_pkg::Ways; i++) insert_key(k);
    send_key(csht_pkg::FUNC_SEARCH, k);
    wait_drained();

    random_traffic(200);
    idle_pct = 61;
    random_traffic(180);
    wait_drained();
    idle_pct = 0;
    stall_pct = 61;
    hold_seq = hold_seq + 1;
    random_traffic(180);
    idle_pct = 29;
    stall_pct = 29;
    random_traffic(200);

    wait_drained();
    repeat (200) @(posedge clk);
    $display("covered %0d key bytes, %0d lookups: inserted %0d, full %0d, found %0d,",
             words_sent, sb.results, sb.st_seen[csht_pkg::ST_INSERTED],
             sb.st_seen[csht_pkg::ST_FULL], sb.st_seen[csht_pkg::ST_FOUND]);
    $display("  missing %0d, too long %0d; %0d errors", sb.st_seen[csht_pkg::ST_MISSING],
             sb.st_seen[csht_pkg::ST_TOO_LONG], sb.errors);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire

[sim.f]
+incdir+rtl
rtl/csht_pkg.sv
rtl/csht_if.sv
rtl/csht_ram.sv
rtl/csht_hash.sv
rtl/csht_table.sv
rtl/chained_string_hash_table_core.sv
verif/tb_chained_string_hash_table_core.sv
